@@ rtl/bsm_pkg.sv @@
`default_nettype none

package bsm_pkg;

   localparam int ACTION_W = 3;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int TARGET_W = 2;
   localparam int MAPPED_W = 19;
   localparam int MIRROR_W = 2;
   localparam int PAIRS_W = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 6;
   localparam int BANK_COUNT = 8;

   localparam logic [ACTION_W-1:0] ACT_CPU_READ = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CPU_WRITE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PPU_ACCESS = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SCANLINE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_IRQ_ACK = 3'd4;

   localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
   localparam logic [TARGET_W-1:0] TGT_PRG_ROM = 2'd1;
   localparam logic [TARGET_W-1:0] TGT_WORK_RAM = 2'd2;
   localparam logic [TARGET_W-1:0] TGT_CHR_ROM = 2'd3;

   localparam logic [MIRROR_W-1:0] MIR_VERTICAL = 2'd0;
   localparam logic [MIRROR_W-1:0] MIR_HORIZONTAL = 2'd1;
   localparam logic [MIRROR_W-1:0] MIR_FOUR_SCREEN = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_BANK_PAIRS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOUR_SCREEN = 1'b1;

   // Upper three CPU address bits select the register window.
   localparam logic [2:0] WIN_WORK_RAM = 3'b011;
   localparam logic [2:0] WIN_BANK = 3'b100;
   localparam logic [2:0] WIN_MIRROR = 3'b101;
   localparam logic [2:0] WIN_IRQ_LATCH = 3'b110;
   localparam logic [2:0] WIN_IRQ_ENABLE = 3'b111;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [MAPPED_W-1:0] mapped_address;
      logic                ram_enable;
      logic                ram_write;
      logic                ram_read;
      logic                irq_pending;
      logic [MIRROR_W-1:0] mirroring_mode;
   } ctrl_type;

endpackage

`default_nettype wire

@@ rtl/bsm_req_if.sv @@
`default_nettype none

interface bsm_req_if;
   import bsm_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   bus_address;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output action, output bus_address, output write_data,
                   input ready);
   modport sink (input valid, input action, input bus_address, input write_data,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/bsm_rsp_if.sv @@
`default_nettype none

interface bsm_rsp_if;
   import bsm_pkg::*;

   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target;
   logic [MAPPED_W-1:0] mapped_address;
   logic [DATA_W-1:0]   read_data;
   logic                irq_pending;
   logic [MIRROR_W-1:0] mirroring_mode;

   modport source (output valid, output target, output mapped_address, output read_data,
                   output irq_pending, output mirroring_mode, input ready);
   modport sink (input valid, input target, input mapped_address, input read_data,
                 input irq_pending, input mirroring_mode, output ready);
endinterface

`default_nettype wire

@@ rtl/bsm_ram.sv @@
`default_nettype none

module bsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] address,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem_ff[address] <= write_data;
         end else begin
            read_data_ff <= mem_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

@@ rtl/bsm_ctrl.sv @@
`default_nettype none

module bsm_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [bsm_pkg::ACTION_W-1:0]     action,
   input  wire logic [bsm_pkg::ADDR_W-1:0]       bus_address,
   input  wire logic [bsm_pkg::DATA_W-1:0]       write_data,
   input  wire logic                             csr_write_enable,
   input  wire logic [bsm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bsm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output bsm_pkg::ctrl_type                     ctrl
);
   import bsm_pkg::*;

   logic [DATA_W-1:0]   bank_regs_ff [BANK_COUNT];
   logic [DATA_W-1:0]   bank_regs_in [BANK_COUNT];
   logic [2:0]          select_index_ff, select_index_in;
   logic                prg_mode_ff, prg_mode_in;
   logic                chr_mode_ff, chr_mode_in;
   logic                ram_enable_ff, ram_enable_in;
   logic [MIRROR_W-1:0] mirror_ff, mirror_in;
   logic [DATA_W-1:0]   irq_latch_ff, irq_latch_in;
   logic [DATA_W-1:0]   irq_count_ff, irq_count_in;
   logic                reload_ff, reload_in;
   logic                irq_enable_ff, irq_enable_in;
   logic                irq_flag_ff, irq_flag_in;
   logic [PAIRS_W-1:0]  pairs_ff, pairs_in;

   logic [2:0]          rd_idx;
   logic [DATA_W-1:0]   bank_q;
   logic                use_fixed;
   logic [PAIRS_W-1:0]  fixed_bank;
   logic [PAIRS_W-1:0]  last_bank;
   logic [PAIRS_W-1:0]  second_last_bank;
   logic [4:0]          pairs_less_one;
   logic [10:0]         chr_offset;
   logic                chr_wide;
   logic [PAIRS_W-1:0]  prg_bank;
   logic [DATA_W-1:0]   bank_data;
   logic [2:0]          window;
   logic                is_ram;

   assign window = bus_address[15:13];
   assign is_ram = (window == WIN_WORK_RAM);
   assign pairs_less_one = pairs_ff[4:0] - 5'd1;
   assign last_bank = {pairs_less_one, 1'b1};
   assign second_last_bank = {pairs_less_one, 1'b0};

   // One bank register is read per request: program or pattern select.
   always_comb begin
      use_fixed = 1'b0;
      fixed_bank = second_last_bank;
      rd_idx = 3'd6;
      chr_offset = {1'b0, bus_address[9:0]};
      chr_wide = 1'b0;
      if (action == ACT_CPU_READ) begin
         unique case (bus_address[14:13])
            2'b00: begin
               use_fixed = prg_mode_ff;
               rd_idx = 3'd6;
            end
            2'b01: begin
               rd_idx = 3'd7;
            end
            2'b10: begin
               use_fixed = !prg_mode_ff;
               rd_idx = 3'd6;
            end
            default: begin
               use_fixed = 1'b1;
               fixed_bank = last_bank;
            end
         endcase
      end else begin
         if ((!bus_address[12]) ^ chr_mode_ff) begin
            chr_wide = 1'b1;
            rd_idx = {2'b00, bus_address[11]};
            chr_offset = bus_address[10:0];
         end else begin
            rd_idx = 3'd2 + {1'b0, bus_address[11:10]};
         end
      end
   end

   assign bank_q = bank_regs_ff[rd_idx];
   assign prg_bank = use_fixed ? fixed_bank : bank_q[PAIRS_W-1:0];

   always_comb begin
      bank_data = write_data;
      if (select_index_ff >= 3'd6) begin
         bank_data = write_data & 8'h3F;
      end else if (select_index_ff <= 3'd1) begin
         bank_data = write_data & 8'hFE;
      end
   end

   always_comb begin
      for (int i = 0; i < BANK_COUNT; i++) begin
         bank_regs_in[i] = bank_regs_ff[i];
      end
      select_index_in = select_index_ff;
      prg_mode_in = prg_mode_ff;
      chr_mode_in = chr_mode_ff;
      ram_enable_in = ram_enable_ff;
      mirror_in = mirror_ff;
      irq_latch_in = irq_latch_ff;
      irq_count_in = irq_count_ff;
      reload_in = reload_ff;
      irq_enable_in = irq_enable_ff;
      irq_flag_in = irq_flag_ff;
      pairs_in = pairs_ff;
      ctrl.target = TGT_NONE;
      ctrl.mapped_address = '0;
      ctrl.ram_enable = 1'b0;
      ctrl.ram_write = 1'b0;
      ctrl.ram_read = 1'b0;

      unique case (action)
         ACT_CPU_READ: begin
            if (is_ram) begin
               if (ram_enable_ff) begin
                  ctrl.target = TGT_WORK_RAM;
                  ctrl.ram_enable = accept;
                  ctrl.ram_read = 1'b1;
               end
            end else if (bus_address[15]) begin
               ctrl.target = TGT_PRG_ROM;
               ctrl.mapped_address = {prg_bank, bus_address[12:0]};
            end
         end
         ACT_CPU_WRITE: begin
            unique case (window)
               WIN_WORK_RAM: begin
                  if (ram_enable_ff) begin
                     ctrl.target = TGT_WORK_RAM;
                     ctrl.ram_enable = accept;
                     ctrl.ram_write = 1'b1;
                  end
               end
               WIN_BANK: begin
                  if (bus_address[0]) begin
                     bank_regs_in[select_index_ff] = bank_data;
                  end else begin
                     select_index_in = write_data[2:0];
                     prg_mode_in = write_data[6];
                     chr_mode_in = write_data[7];
                  end
               end
               WIN_MIRROR: begin
                  if (bus_address[0]) begin
                     ram_enable_in = write_data[7];
                  end else if (mirror_ff != MIR_FOUR_SCREEN) begin
                     mirror_in = write_data[0] ? MIR_HORIZONTAL : MIR_VERTICAL;
                  end
               end
               WIN_IRQ_LATCH: begin
                  if (bus_address[0]) begin
                     reload_in = 1'b1;
                  end else begin
                     irq_latch_in = write_data;
                  end
               end
               WIN_IRQ_ENABLE: begin
                  if (bus_address[0]) begin
                     irq_enable_in = 1'b1;
                  end else begin
                     irq_enable_in = 1'b0;
                     irq_flag_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         ACT_PPU_ACCESS: begin
            if (window == 3'b000) begin
               ctrl.target = TGT_CHR_ROM;
               if (chr_wide) begin
                  ctrl.mapped_address = {1'b0, bank_q, 10'b0} + {8'b0, chr_offset};
               end else begin
                  ctrl.mapped_address = {1'b0, bank_q, chr_offset[9:0]};
               end
            end
         end
         ACT_SCANLINE: begin
            if ((irq_count_ff == '0) || reload_ff) begin
               irq_count_in = irq_latch_ff;
               reload_in = 1'b0;
            end else begin
               irq_count_in = irq_count_ff - 8'd1;
            end
            if ((irq_count_in == '0) && irq_enable_ff) begin
               irq_flag_in = 1'b1;
            end
         end
         ACT_IRQ_ACK: begin
            irq_flag_in = 1'b0;
         end
         default: begin
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRG_BANK_PAIRS: begin
               pairs_in = csr_write_data;
            end
            CSR_FOUR_SCREEN: begin
               if (csr_write_data[0]) begin
                  mirror_in = MIR_FOUR_SCREEN;
               end else if (mirror_ff == MIR_FOUR_SCREEN) begin
                  mirror_in = MIR_VERTICAL;
               end
            end
            default: begin
            end
         endcase
      end

      ctrl.irq_pending = irq_flag_in;
      ctrl.mirroring_mode = mirror_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANK_COUNT; i++) begin
            bank_regs_ff[i] <= '0;
         end
         select_index_ff <= '0;
         prg_mode_ff <= 1'b0;
         chr_mode_ff <= 1'b0;
         ram_enable_ff <= 1'b1;
         mirror_ff <= MIR_VERTICAL;
         irq_latch_ff <= '0;
         irq_count_ff <= '0;
         reload_ff <= 1'b0;
         irq_enable_ff <= 1'b0;
         irq_flag_ff <= 1'b0;
         pairs_ff <= 6'd1;
      end else begin
         if (accept) begin
            for (int i = 0; i < BANK_COUNT; i++) begin
               bank_regs_ff[i] <= bank_regs_in[i];
            end
            select_index_ff <= select_index_in;
            prg_mode_ff <= prg_mode_in;
            chr_mode_ff <= chr_mode_in;
            ram_enable_ff <= ram_enable_in;
            irq_latch_ff <= irq_latch_in;
            irq_count_ff <= irq_count_in;
            reload_ff <= reload_in;
            irq_enable_ff <= irq_enable_in;
            irq_flag_ff <= irq_flag_in;
         end
         if (accept || csr_write_enable) begin
            mirror_ff <= mirror_in;
         end
         if (csr_write_enable) begin
            pairs_ff <= pairs_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/bank_switch_mapper_scanline_irq.sv @@
// Each result appears in the cycle after its request is accepted; one request
// per cycle is taken unless stalled; the single work RAM port serves one read
// or one write per request, and read data returns from its output register.
// Reset is synchronous and active high; it resets all control state at once.
// Work RAM contents are undefined after reset and need no clearing pass.
`default_nettype none

module bank_switch_mapper_scanline_irq #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bsm_req_if.sink                              req,
   bsm_rsp_if.source                            rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [bsm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bsm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bsm_pkg::*;

   localparam int RAM_AW = $clog2(WORK_RAM_DEPTH);
   localparam logic [17:0] DEPTH_X1 = 18'(WORK_RAM_DEPTH);
   localparam logic [17:0] DEPTH_X2 = 18'(2 * WORK_RAM_DEPTH);
   localparam logic [17:0] DEPTH_X4 = 18'(4 * WORK_RAM_DEPTH);

   ctrl_type            ctrl;
   logic                accept;
   logic [17:0]         idx_0, idx_1, idx_2, idx_3;
   logic [RAM_AW-1:0]   ram_address;
   logic [DATA_W-1:0]   ram_q;

   logic                rsp_valid_ff;
   logic [TARGET_W-1:0] target_ff;
   logic [MAPPED_W-1:0] mapped_ff;
   logic                ram_read_ff;
   logic                irq_pending_ff;
   logic [MIRROR_W-1:0] mirror_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   bsm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .action           (req.action),
      .bus_address      (req.bus_address),
      .write_data       (req.write_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl)
   );

   // The window offset is below eight times the depth, so three restoring
   // steps reduce it modulo the depth.
   always_comb begin
      idx_0 = {5'b0, req.bus_address[12:0]};
      idx_1 = (idx_0 >= DEPTH_X4) ? idx_0 - DEPTH_X4 : idx_0;
      idx_2 = (idx_1 >= DEPTH_X2) ? idx_1 - DEPTH_X2 : idx_1;
      idx_3 = (idx_2 >= DEPTH_X1) ? idx_2 - DEPTH_X1 : idx_2;
   end

   assign ram_address = idx_3[RAM_AW-1:0];

   bsm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WORK_RAM_DEPTH)
   ) u_work_ram (
      .clock        (clock),
      .enable       (ctrl.ram_enable),
      .write_enable (ctrl.ram_write),
      .address      (ram_address),
      .write_data   (req.write_data),
      .read_data    (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= ctrl.target;
         mapped_ff <= ctrl.mapped_address;
         ram_read_ff <= ctrl.ram_read;
         irq_pending_ff <= ctrl.irq_pending;
         mirror_ff <= ctrl.mirroring_mode;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.target = target_ff;
   assign rsp.mapped_address = mapped_ff;
   assign rsp.read_data = ram_read_ff ? ram_q : '0;
   assign rsp.irq_pending = irq_pending_ff;
   assign rsp.mirroring_mode = mirror_ff;

endmodule

`default_nettype wire
